// ----- hw/rtl/tcce_pkg.sv -----
// Package for the text console cursor engine.
// Holds the command codes, character codes, the reset attribute and the sequencer states.
// No dependencies.
package tcce_pkg;

  localparam int unsigned CMD_W   = 2;
  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned IDX_W   = 11;
  localparam int unsigned CELL_W  = 16;
  localparam int unsigned OROW_W  = 5;
  localparam int unsigned OCOL_W  = 7;

  localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

  localparam logic [CHAR_W-1:0] CODE_BACKSPACE = 8'd8;
  localparam logic [CHAR_W-1:0] CODE_NEWLINE   = 8'd10;
  localparam logic [CHAR_W-1:0] CODE_SPACE     = 8'd32;

  localparam logic [CHAR_W-1:0] RESET_ATTR = 8'd7;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_READ,
    ST_SCROLL,
    ST_FILL
  } state_t;

endpackage

// ----- hw/rtl/tcce_ram.sv -----
// Generic simple dual-port RAM with one write port and one registered read port.
// Used as the character store of the console engine. No dependencies.
module tcce_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/text_console_cursor_engine_top.sv -----
// Text console engine: character store, cursor, scroll and clear sequencer.
// Put character and the unused command return a word in the cycle after acceptance unless a
// put scrolls; read passes ST_READ, then the output register. A scroll copies each store row
// up one row, blanks the last row, then returns its word; clear blanks every cell and returns
// its word too. The single store write/read port sets the pace. After reset a pass blanks the
// store with attribute 7; no word is accepted meanwhile. Depends on tcce_pkg and tcce_ram.
module text_console_cursor_engine_top
  import tcce_pkg::*;
#(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data,      // attribute
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,      // char_code[7:0], cell_index[18:8], zero pad
  input  logic [1:0]  in_tuser,      // command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata      // read_entry, cursor_row, cursor_column, scrolled, pad
);

  localparam int unsigned CELLS = ROWS * COLUMNS;
  localparam int unsigned AW    = $clog2(CELLS);
  localparam int unsigned CNTW  = $clog2(CELLS + 1);
  localparam int unsigned IW    = (CNTW > IDX_W) ? CNTW : IDX_W;
  localparam int unsigned RW    = $clog2(ROWS);
  localparam int unsigned CW    = $clog2(COLUMNS);
  localparam int unsigned RXW   = RW + OROW_W;
  localparam int unsigned CXW   = CW + OCOL_W;

  state_t state_r, state_nxt;

  logic [RW-1:0]     row_r, row_nxt;
  logic [CW-1:0]     col_r, col_nxt;
  logic [AW-1:0]     addr_r, addr_nxt;
  logic [CNTW-1:0]   cnt_r, cnt_nxt;
  logic              pend_r, pend_nxt;
  logic              sc_r, sc_nxt;
  logic              rd_ok_r, rd_ok_nxt;
  logic [CHAR_W-1:0] attr_r;
  logic              out_valid_r, out_valid_nxt;
  logic [31:0]       out_data_r, out_data_nxt;

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [CELL_W-1:0] mem_wdata;
  logic [AW-1:0]     mem_raddr;
  logic [CELL_W-1:0] mem_rdata;

  logic              acc;
  logic [CMD_W-1:0]  cmd;
  logic [CHAR_W-1:0] ch;
  logic [IW-1:0]     idx_ext;
  logic [CNTW-1:0]   wr_back;
  logic [RXW-1:0]    row_ext;
  logic [CXW-1:0]    col_ext;
  logic              load;
  logic              load_scr;
  logic [CELL_W-1:0] load_entry;

  assign cmd       = in_tuser;
  assign ch        = in_tdata[7:0];
  assign idx_ext   = IW'(in_tdata[18:8]);
  assign cfg_ready = (state_r == ST_IDLE) && !out_valid_r && !in_tvalid;
  assign in_tready = (state_r == ST_IDLE) && (!out_valid_r || out_tready);
  assign acc       = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign wr_back   = cnt_r - CNTW'(COLUMNS + 1);

  tcce_ram #(
    .WIDTH(CELL_W),
    .DEPTH(CELLS)
  ) u_store (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_INIT: begin
        if (cnt_r == CNTW'(CELLS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (acc) begin
          case (cmd)
            CMD_PUT: begin
              if (ch == CODE_NEWLINE && row_r == RW'(ROWS - 1)) begin
                state_nxt = ST_SCROLL;
              end else if (ch != CODE_NEWLINE && ch != CODE_BACKSPACE &&
                           col_r == CW'(COLUMNS - 1) && row_r == RW'(ROWS - 1)) begin
                state_nxt = ST_SCROLL;
              end
            end
            CMD_CLEAR: state_nxt = ST_FILL;
            CMD_READ:  state_nxt = ST_READ;
            default:   state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_READ: state_nxt = ST_IDLE;
      ST_SCROLL: begin
        if (cnt_r == CNTW'(CELLS)) begin
          state_nxt = ST_FILL;
        end
      end
      ST_FILL: begin
        if (cnt_r == CNTW'(CELLS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_INIT;
    endcase
  end

  always_comb begin
    row_nxt    = row_r;
    col_nxt    = col_r;
    addr_nxt   = addr_r;
    cnt_nxt    = cnt_r;
    pend_nxt   = 1'b0;
    sc_nxt     = sc_r;
    rd_ok_nxt  = rd_ok_r;
    mem_we     = 1'b0;
    mem_waddr  = addr_r;
    mem_wdata  = {attr_r, CODE_SPACE};
    mem_raddr  = cnt_r[AW-1:0];
    load       = 1'b0;
    load_scr   = 1'b0;
    load_entry = '0;
    case (state_r)
      ST_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_r[AW-1:0];
        mem_wdata = {RESET_ATTR, CODE_SPACE};
        cnt_nxt   = (cnt_r == CNTW'(CELLS - 1)) ? '0 : cnt_r + 1'b1;
      end
      ST_IDLE: begin
        mem_raddr = idx_ext[AW-1:0];
        if (acc) begin
          case (cmd)
            CMD_PUT: begin
              if (ch == CODE_BACKSPACE) begin
                if (col_r != '0) begin
                  col_nxt  = col_r - 1'b1;
                  addr_nxt = addr_r - 1'b1;
                end else if (row_r != '0) begin
                  row_nxt  = row_r - 1'b1;
                  col_nxt  = CW'(COLUMNS - 1);
                  addr_nxt = addr_r - 1'b1;
                end
                mem_we    = 1'b1;
                mem_waddr = addr_nxt;
                load      = 1'b1;
              end else if (ch == CODE_NEWLINE) begin
                col_nxt = '0;
                if (row_r == RW'(ROWS - 1)) begin
                  addr_nxt = AW'(CELLS - COLUMNS);
                  cnt_nxt  = CNTW'(COLUMNS);
                  sc_nxt   = 1'b1;
                end else begin
                  row_nxt  = row_r + 1'b1;
                  addr_nxt = addr_r - AW'(col_r) + AW'(COLUMNS);
                  load     = 1'b1;
                end
              end else begin
                mem_we    = 1'b1;
                mem_wdata = {attr_r, ch};
                if (col_r == CW'(COLUMNS - 1)) begin
                  col_nxt = '0;
                  if (row_r == RW'(ROWS - 1)) begin
                    addr_nxt = AW'(CELLS - COLUMNS);
                    cnt_nxt  = CNTW'(COLUMNS);
                    sc_nxt   = 1'b1;
                  end else begin
                    row_nxt  = row_r + 1'b1;
                    addr_nxt = addr_r + 1'b1;
                    load     = 1'b1;
                  end
                end else begin
                  col_nxt  = col_r + 1'b1;
                  addr_nxt = addr_r + 1'b1;
                  load     = 1'b1;
                end
              end
            end
            CMD_CLEAR: begin
              row_nxt  = '0;
              col_nxt  = '0;
              addr_nxt = '0;
              cnt_nxt  = '0;
              sc_nxt   = 1'b0;
            end
            CMD_READ: begin
              rd_ok_nxt = (idx_ext < IW'(CELLS));
            end
            default: begin
              load = 1'b1;
            end
          endcase
        end
      end
      ST_READ: begin
        load       = 1'b1;
        load_entry = rd_ok_r ? mem_rdata : '0;
      end
      ST_SCROLL: begin
        mem_raddr = cnt_r[AW-1:0];
        mem_we    = pend_r;
        mem_waddr = wr_back[AW-1:0];
        mem_wdata = mem_rdata;
        if (cnt_r == CNTW'(CELLS)) begin
          cnt_nxt = CNTW'(CELLS - COLUMNS);
        end else begin
          cnt_nxt  = cnt_r + 1'b1;
          pend_nxt = 1'b1;
        end
      end
      ST_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_r[AW-1:0];
        if (cnt_r == CNTW'(CELLS - 1)) begin
          cnt_nxt  = '0;
          load     = 1'b1;
          load_scr = sc_r;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      default: begin
        cnt_nxt = '0;
      end
    endcase
  end

  always_comb begin
    row_ext       = RXW'(row_nxt);
    col_ext       = CXW'(col_nxt);
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    if (load) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {3'b000, load_scr, col_ext[OCOL_W-1:0], row_ext[OROW_W-1:0], load_entry};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      row_r       <= '0;
      col_r       <= '0;
      addr_r      <= '0;
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      sc_r        <= 1'b0;
      rd_ok_r     <= 1'b0;
      attr_r      <= RESET_ATTR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      addr_r      <= addr_nxt;
      cnt_r       <= cnt_nxt;
      pend_r      <= pend_nxt;
      sc_r        <= sc_nxt;
      rd_ok_r     <= rd_ok_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        attr_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

endmodule
